### rtl/pdc_pkg.sv
// pdc_pkg: constants and helpers for the packet deframer / checker
// holds header layout, status codes, register indexes and the ones' complement add
// no dependencies
package pdc_pkg;

    localparam int COUNT_W = 17;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [15:0]        word_t;
    typedef logic [2:0]         status_t;
    typedef logic [1:0]         cfg_index_t;

    localparam count_t HDR_BYTES = 17'd9;
    localparam count_t COUNT_MAX = 17'h1FFFF;
    localparam word_t  ALL_ONES  = 16'hFFFF;

    // header byte positions
    localparam count_t POS_FLAGS  = 17'd4;
    localparam count_t POS_CK_HI  = 17'd5;
    localparam count_t POS_CK_LO  = 17'd6;
    localparam count_t POS_LEN_HI = 17'd7;
    localparam count_t POS_LEN_LO = 17'd8;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_TOO_SHORT = 3'd1;
    localparam status_t ST_BAD_FLAGS = 3'd2;
    localparam status_t ST_LEN_ERR   = 3'd3;
    localparam status_t ST_CK_ERR    = 3'd4;

    localparam cfg_index_t REG_FLAG_DATA = 2'd0;
    localparam cfg_index_t REG_FLAG_ACK  = 2'd1;
    localparam cfg_index_t REG_FLAG_FIN  = 2'd2;

    localparam logic [7:0] FLAG_DATA_RESET = 8'd1;
    localparam logic [7:0] FLAG_ACK_RESET  = 8'd2;
    localparam logic [7:0] FLAG_FIN_RESET  = 8'd4;

    // 16-bit ones' complement add with end-around carry
    function automatic word_t ones_add(input word_t a, input word_t b);
        logic [16:0] t;
        logic [16:0] u;
        begin
            t = {1'b0, a} + {1'b0, b};
            u = {1'b0, t[15:0]} + {16'd0, t[16]};
            ones_add = u[15:0];
        end
    endfunction

endpackage

### rtl/packet_deframer_checker.sv
// packet_deframer_checker: byte-serial frame receiver with header capture and
// ones' complement checksum verdict
// depends on pdc_pkg
//
// usage:
//   input channel (in_valid / in_stall) carries one frame byte per beat with
//   last_byte marking the final byte. the first 9 bytes are a big-endian header
//   (sequence, flags, checksum, payload length); later bytes are payload.
//   output channel (out_valid / out_stall) gives one result beat for every
//   payload byte and for the last byte of a frame; header bytes that are not
//   last give no beat. the last-byte beat has frame_done set with the verdict
//   in status and the captured header fields.
//   a result is registered as its byte is taken. throughput is one byte per
//   cycle while no result is held by out_stall. the output register frees as
//   its beat is taken, so in_stall rises only while a result is held by
//   out_stall. reset clears the frame state and loads the flags registers
//   with 1, 2, 4. the cfg port writes a flags register; the user must write
//   it only while idle, which the block itself does not enforce.
module packet_deframer_checker
    import pdc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  cfg_index_t   cfg_index,
    input  logic [7:0]   cfg_data,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         payload_valid,
    output logic [7:0]   payload_byte,
    output logic         frame_done,
    output status_t      status,
    output logic [31:0]  seq_num,
    output logic [7:0]   flags_out,
    output logic [15:0]  checksum_field,
    output logic [15:0]  payload_length
);

    logic [7:0]  flag_data_reg;
    logic [7:0]  flag_ack_reg;
    logic [7:0]  flag_fin_reg;

    count_t      byte_count_reg, byte_count_next;
    word_t       ones_sum_reg, ones_sum_next;
    logic [7:0]  pending_high_reg, pending_high_next;
    logic [31:0] seq_reg, seq_next;
    logic [7:0]  flags_reg, flags_next;
    word_t       cksum_reg, cksum_next;
    word_t       length_reg, length_next;

    logic        out_valid_reg;
    logic        payload_valid_reg, payload_valid_next;
    logic [7:0]  payload_byte_reg, payload_byte_next;
    logic        frame_done_reg;
    status_t     status_reg, status_next;
    logic [31:0] seq_num_reg, seq_num_next;
    logic [7:0]  flags_out_reg, flags_out_next;
    word_t       checksum_field_reg, checksum_field_next;
    word_t       payload_length_reg, payload_length_next;

    logic        in_accept;
    logic        emit;
    logic        is_payload;
    logic        flags_ok;
    count_t      body_len;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_data_reg <= FLAG_DATA_RESET;
            flag_ack_reg  <= FLAG_ACK_RESET;
            flag_fin_reg  <= FLAG_FIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FLAG_DATA: flag_data_reg <= cfg_data;
                REG_FLAG_ACK:  flag_ack_reg  <= cfg_data;
                REG_FLAG_FIN:  flag_fin_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // per-byte update and result
    always_comb
    begin
        seq_next          = seq_reg;
        flags_next        = flags_reg;
        cksum_next        = cksum_reg;
        length_next       = length_reg;
        ones_sum_next     = ones_sum_reg;
        pending_high_next = pending_high_reg;
        byte_count_next   = byte_count_reg;

        is_payload = (byte_count_reg >= HDR_BYTES);

        if (byte_count_reg < POS_FLAGS)
        begin
            case (byte_count_reg[1:0])
                2'd0:    seq_next[31:24] = data_byte;
                2'd1:    seq_next[23:16] = data_byte;
                2'd2:    seq_next[15:8]  = data_byte;
                default: seq_next[7:0]   = data_byte;
            endcase
        end
        else if (byte_count_reg == POS_FLAGS)
            flags_next = data_byte;
        else if (byte_count_reg == POS_CK_HI)
            cksum_next[15:8] = data_byte;
        else if (byte_count_reg == POS_CK_LO)
            cksum_next[7:0] = data_byte;
        else if (byte_count_reg == POS_LEN_HI)
            length_next[15:8] = data_byte;
        else if (byte_count_reg == POS_LEN_LO)
            length_next[7:0] = data_byte;

        // counter saturates; bytes past that point are not summed
        if (byte_count_reg != COUNT_MAX)
        begin
            if (!byte_count_reg[0])
            begin
                if (last_byte)
                    ones_sum_next = ones_add(ones_sum_reg, {data_byte, 8'h00});
                else
                    pending_high_next = data_byte;
            end
            else
                ones_sum_next = ones_add(ones_sum_reg, {pending_high_reg, data_byte});
            byte_count_next = byte_count_reg + 17'd1;
        end

        flags_ok = (flags_next == flag_data_reg) || (flags_next == flag_ack_reg) ||
                   (flags_next == flag_fin_reg);
        body_len = byte_count_next - HDR_BYTES;

        if (byte_count_next < HDR_BYTES)
            status_next = ST_TOO_SHORT;
        else if (!flags_ok)
            status_next = ST_BAD_FLAGS;
        else if (body_len != {1'b0, length_next})
            status_next = ST_LEN_ERR;
        else if (ones_sum_next != ALL_ONES)
            status_next = ST_CK_ERR;
        else
            status_next = ST_OK;

        emit               = is_payload || last_byte;
        payload_valid_next = is_payload;
        payload_byte_next  = is_payload ? data_byte : 8'd0;

        if (last_byte)
        begin
            seq_num_next        = seq_next;
            flags_out_next      = flags_next;
            checksum_field_next = cksum_next;
            payload_length_next = length_next;
        end
        else
        begin
            status_next         = ST_OK;
            seq_num_next        = '0;
            flags_out_next      = '0;
            checksum_field_next = '0;
            payload_length_next = '0;
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            ones_sum_reg     <= '0;
            pending_high_reg <= '0;
            seq_reg          <= '0;
            flags_reg        <= '0;
            cksum_reg        <= '0;
            length_reg       <= '0;
        end
        else if (in_accept)
        begin
            if (last_byte)
            begin
                byte_count_reg   <= '0;
                ones_sum_reg     <= '0;
                pending_high_reg <= '0;
                seq_reg          <= '0;
                flags_reg        <= '0;
                cksum_reg        <= '0;
                length_reg       <= '0;
            end
            else
            begin
                byte_count_reg   <= byte_count_next;
                ones_sum_reg     <= ones_sum_next;
                pending_high_reg <= pending_high_next;
                seq_reg          <= seq_next;
                flags_reg        <= flags_next;
                cksum_reg        <= cksum_next;
                length_reg       <= length_next;
            end
        end
    end

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept && emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && emit)
        begin
            payload_valid_reg  <= payload_valid_next;
            payload_byte_reg   <= payload_byte_next;
            frame_done_reg     <= last_byte;
            status_reg         <= status_next;
            seq_num_reg        <= seq_num_next;
            flags_out_reg      <= flags_out_next;
            checksum_field_reg <= checksum_field_next;
            payload_length_reg <= payload_length_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign payload_valid  = payload_valid_reg;
    assign payload_byte   = payload_byte_reg;
    assign frame_done     = frame_done_reg;
    assign status         = status_reg;
    assign seq_num        = seq_num_reg;
    assign flags_out      = flags_out_reg;
    assign checksum_field = checksum_field_reg;
    assign payload_length = payload_length_reg;

    // the input side only stalls behind a held result
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result held");

    // a beat without frame_done must be a payload byte with empty verdict fields
    a_mid_frame_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_done |-> payload_valid && status == ST_OK && seq_num == 32'd0)
        else $error("mid-frame beat is not a clean payload beat");

    // a too-short frame never carried payload
    a_short_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done && status == ST_TOO_SHORT |-> !payload_valid)
        else $error("short frame verdict on a payload byte");

    // frame state is cleared after the last byte
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && last_byte |=> byte_count_reg == 17'd0 && ones_sum_reg == 16'd0)
        else $error("frame state not cleared after last byte");

endmodule

### bench/tb_packet_deframer_checker.sv
// tb_packet_deframer_checker: self-checking bench for the packet deframer / checker
// streams framed bytes with random gaps and back-pressure, predicts and checks each result beat
// depends on pdc_pkg and packet_deframer_checker
module tb_packet_deframer_checker;
    timeunit 1ns;
    timeprecision 1ps;

    import pdc_pkg::*;

    localparam int CYCLE_LIMIT            = 1_000_000;
    localparam int RANDOM_BYTES_PER_PHASE = 300;
    localparam int OVERSIZE_BYTES         = 131075;
    localparam int LONG_HOLD              = 150;
    localparam int SETTLE_CYCLES          = 4;
    localparam int SHOW_MAX               = 10;

    localparam cfg_index_t REG_SPARE = 2'd3;

    typedef struct packed {
        logic        pv;
        logic [7:0]  pb;
        logic        done;
        status_t     st;
        logic [31:0] seq;
        logic [7:0]  flags;
        logic [15:0] ck;
        logic [15:0] len;
    } frame_result_t;

    typedef struct packed {
        logic [7:0]    data;
        logic          lst;
        logic          typed;
        frame_result_t want;
    } dir_row_t;

    typedef enum int {
        FR_NOISE,
        FR_BAD_FLAGS,
        FR_BAD_LEN,
        FR_BIT_FLIP,
        FR_SHORT_HDR,
        FR_SHORT_PAYLOAD,
        FR_EXTRA,
        FR_CLEAN
    } frame_kind_t;

    localparam frame_result_t NO_CHECK = '0;

    localparam dir_row_t DIRECTED_ROWS [0:19] = '{
        // one-byte frame: too short, that byte lands in the top of the sequence number
        '{8'hFF, 1'b1, 1'b1,
          '{1'b0, 8'h00, 1'b1, ST_TOO_SHORT, 32'hFF00_0000, 8'h00, 16'h0000, 16'h0000}},
        // bare header, flags zero matches no configured value
        '{8'hFF, 1'b0, 1'b0, NO_CHECK},
        '{8'hFF, 1'b0, 1'b0, NO_CHECK},
        '{8'hFF, 1'b0, 1'b0, NO_CHECK},
        '{8'hFF, 1'b0, 1'b0, NO_CHECK},
        '{8'h00, 1'b0, 1'b0, NO_CHECK},
        '{8'h00, 1'b0, 1'b0, NO_CHECK},
        '{8'h00, 1'b0, 1'b0, NO_CHECK},
        '{8'h00, 1'b0, 1'b0, NO_CHECK},
        '{8'h00, 1'b1, 1'b1,
          '{1'b0, 8'h00, 1'b1, ST_BAD_FLAGS, 32'hFFFF_FFFF, 8'h00, 16'h0000, 16'h0000}},
        // fin frame, one payload byte, checksum chosen so the folded sum is all ones
        '{8'h00, 1'b0, 1'b0, NO_CHECK},
        '{8'h00, 1'b0, 1'b0, NO_CHECK},
        '{8'h00, 1'b0, 1'b0, NO_CHECK},
        '{8'h00, 1'b0, 1'b0, NO_CHECK},
        '{8'h04, 1'b0, 1'b0, NO_CHECK},
        '{8'h00, 1'b0, 1'b0, NO_CHECK},
        '{8'hFA, 1'b0, 1'b0, NO_CHECK},
        '{8'h00, 1'b0, 1'b0, NO_CHECK},
        '{8'h01, 1'b0, 1'b0, NO_CHECK},
        '{8'hFF, 1'b1, 1'b1,
          '{1'b1, 8'hFF, 1'b1, ST_OK, 32'h0000_0000, 8'h04, 16'h00FA, 16'h0001}}
    };

    localparam cfg_index_t FLAG_REGS [3] = '{REG_FLAG_DATA, REG_FLAG_ACK, REG_FLAG_FIN};

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    cfg_index_t   cfg_index;
    logic [7:0]   cfg_data;
    logic         in_valid;
    logic         in_stall;
    logic [7:0]   data_byte;
    logic         last_byte;
    logic         out_valid;
    logic         out_stall;
    logic         payload_valid;
    logic [7:0]   payload_byte;
    logic         frame_done;
    status_t      status;
    logic [31:0]  seq_num;
    logic [7:0]   flags_out;
    logic [15:0]  checksum_field;
    logic [15:0]  payload_length;

    // predictor copy of the block state
    logic [7:0]   flag_ok [3] = '{FLAG_DATA_RESET, FLAG_ACK_RESET, FLAG_FIN_RESET};
    count_t       rx_count = '0;
    logic [15:0]  rx_sum   = '0;
    logic [7:0]   rx_high  = '0;
    logic [31:0]  rx_seq   = '0;
    logic [7:0]   rx_flags = '0;
    logic [15:0]  rx_ck    = '0;
    logic [15:0]  rx_len   = '0;

    frame_result_t pending_beats [$];

    bit           idling = 1'b1;
    bit           hold_req = 1'b0;
    int           bytes_sent = 0;
    int           frames_done = 0;
    int           beats_checked = 0;
    int           mismatches = 0;
    int           status_seen [8] = '{default: 0};
    int unsigned  cycles = 0;

    packet_deframer_checker uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .payload_valid  (payload_valid),
        .payload_byte   (payload_byte),
        .frame_done     (frame_done),
        .status         (status),
        .seq_num        (seq_num),
        .flags_out      (flags_out),
        .checksum_field (checksum_field),
        .payload_length (payload_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // end-around carry add of two 16-bit words
    function automatic logic [15:0] ones_fold(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    function automatic string beat_text(input frame_result_t r);
        return $sformatf("pv=%0d pb=%02h done=%0d st=%0d seq=%08h fl=%02h ck=%04h len=%04h",
                         r.pv, r.pb, r.done, r.st, r.seq, r.flags, r.ck, r.len);
    endfunction

    // advance the frame state by one byte, returns 1 when the byte yields a result beat
    function automatic bit deframe_byte(input logic [7:0] b, input logic lst,
                                        output frame_result_t r);
        count_t pos;
        logic   payload;
        pos = rx_count;
        payload = (pos >= HDR_BYTES);
        if (pos < POS_FLAGS)
            rx_seq[8 * (3 - pos[1:0]) +: 8] = b;
        else if (pos == POS_FLAGS)
            rx_flags = b;
        else if (pos == POS_CK_HI)
            rx_ck[15:8] = b;
        else if (pos == POS_CK_LO)
            rx_ck[7:0] = b;
        else if (pos == POS_LEN_HI)
            rx_len[15:8] = b;
        else if (pos == POS_LEN_LO)
            rx_len[7:0] = b;

        // a saturated counter stops the sum
        if (pos != COUNT_MAX)
        begin
            if (!pos[0])
            begin
                if (lst)
                    rx_sum = ones_fold(rx_sum, {b, 8'h00});
                else
                    rx_high = b;
            end
            else
                rx_sum = ones_fold(rx_sum, {rx_high, b});
            rx_count = pos + 17'd1;
        end

        r = '0;
        r.pv = payload;
        if (payload)
            r.pb = b;
        if (lst)
        begin
            r.done = 1'b1;
            r.seq = rx_seq;
            r.flags = rx_flags;
            r.ck = rx_ck;
            r.len = rx_len;
            if (rx_count < HDR_BYTES)
                r.st = ST_TOO_SHORT;
            else if (rx_flags != flag_ok[0] && rx_flags != flag_ok[1] && rx_flags != flag_ok[2])
                r.st = ST_BAD_FLAGS;
            else if (rx_count - HDR_BYTES != {1'b0, rx_len})
                r.st = ST_LEN_ERR;
            else if (rx_sum != ALL_ONES)
                r.st = ST_CK_ERR;
            else
                r.st = ST_OK;
            status_seen[r.st]++;
            frames_done++;
            rx_count = '0;
            rx_sum = '0;
            rx_high = '0;
            rx_seq = '0;
            rx_flags = '0;
            rx_ck = '0;
            rx_len = '0;
        end
        return lst || payload;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
                             input frame_result_t want);
        frame_result_t r;
        @(negedge clk);
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= lst;
        do
            @(posedge clk);
        while (in_stall);
        if (deframe_byte(b, lst, r))
            pending_beats.push_back(typed ? want : r);
        bytes_sent++;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7) - 1) @(negedge clk);
        end
    endtask

    // builds one frame, mostly well formed with a matching checksum, then streams it
    task automatic send_random_frame(input int big_payload);
        logic [7:0]  fr [$];
        frame_kind_t kind;
        int          plen;
        int          pos;
        int          keep;
        logic [15:0] s;
        logic [15:0] fix;
        if (big_payload > 0)
            kind = FR_CLEAN;
        else if ($urandom_range(0, 9) < 6)
            kind = FR_CLEAN;
        else
            kind = frame_kind_t'($urandom_range(0, 6));
        if (big_payload > 0)
            plen = big_payload;
        else if ($urandom_range(0, 7) == 0)
            plen = $urandom_range(7, 48);
        else
            plen = $urandom_range(0, 6);

        if (kind == FR_NOISE)
        begin
            repeat ($urandom_range(1, 24)) fr.push_back(8'($urandom()));
        end
        else
        begin
            repeat (4) fr.push_back(8'($urandom()));
            fr.push_back(flag_ok[$urandom_range(0, 2)]);
            fr.push_back(8'h00);
            fr.push_back(8'h00);
            fr.push_back(8'(plen >> 8));
            fr.push_back(8'(plen));
            repeat (plen) fr.push_back(8'($urandom()));
            s = '0;
            for (pos = 0; pos < fr.size(); pos += 2)
                s = ones_fold(s, {fr[pos], (pos + 1 < fr.size()) ? fr[pos + 1] : 8'h00});
            // checksum bytes straddle two words, so its halves land swapped
            fix = ~s;
            fr[5] = fix[7:0];
            fr[6] = fix[15:8];
            case (kind)
                FR_BAD_FLAGS:
                    fr[4] = 8'($urandom());
                FR_BAD_LEN:
                    fr[8] = fr[8] + 8'($urandom_range(1, 3));
                FR_BIT_FLIP:
                begin
                    pos = $urandom_range(0, fr.size() - 1);
                    fr[pos] = fr[pos] ^ 8'(1 << $urandom_range(0, 7));
                end
                FR_SHORT_HDR:
                begin
                    keep = $urandom_range(1, 8);
                    while (fr.size() > keep) void'(fr.pop_back());
                end
                FR_SHORT_PAYLOAD:
                begin
                    if (plen > 0)
                    begin
                        keep = 9 + $urandom_range(0, plen - 1);
                        while (fr.size() > keep) void'(fr.pop_back());
                    end
                end
                FR_EXTRA:
                    repeat ($urandom_range(1, 3)) fr.push_back(8'($urandom()));
                default:
                    ;
            endcase
        end
        foreach (fr[i])
            send_byte(fr[i], i == fr.size() - 1, 1'b0, NO_CHECK);
    endtask

    // frame past the 17-bit byte counter, must end as a length mismatch
    task automatic send_oversize_frame();
        int         n;
        logic [7:0] b;
        for (n = 0; n < OVERSIZE_BYTES; n++)
        begin
            b = (n == 4) ? flag_ok[0] : 8'($urandom());
            send_byte(b, n == OVERSIZE_BYTES - 1, 1'b0, NO_CHECK);
        end
    endtask

    task automatic settle_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge clk);
        // header bytes give no beat, so allow the pipe to empty
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_flag(input cfg_index_t idx, input logic [7:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FLAG_DATA: flag_ok[0] = v;
            REG_FLAG_ACK:  flag_ok[1] = v;
            REG_FLAG_FIN:  flag_ok[2] = v;
            default:       ;
        endcase
    endtask

    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                // long hold-off while the sender keeps offering bytes
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (idling && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : beat_check
        frame_result_t got;
        frame_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {payload_valid, payload_byte, frame_done, status, seq_num, flags_out,
                   checksum_field, payload_length};
            if (pending_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("unexpected beat: %s", beat_text(got));
            end
            else
            begin
                want = pending_beats.pop_front();
                beats_checked++;
                if (got.pv !== want.pv || got.pb !== want.pb || got.done !== want.done ||
                    got.st !== want.st || got.seq !== want.seq || got.flags !== want.flags ||
                    got.ck !== want.ck || got.len !== want.len)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display("beat %0d mismatch\n  expected %s\n  actual   %s",
                                 beats_checked, beat_text(want), beat_text(got));
                end
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d beats still expected",
                 cycles, pending_beats.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int         phase;
        int         slot;
        int         start;
        logic [7:0] plan [4][3];

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_FLAG_DATA;
        cfg_data = 8'h00;
        in_valid = 1'b0;
        data_byte = 8'h00;
        last_byte = 1'b0;

        plan = '{'{8'h00, 8'h00, 8'h00},
                 '{8'hFF, 8'hFF, 8'hFF},
                 '{8'h00, 8'h00, 8'h00},
                 '{8'h00, 8'h80, 8'hFF}};
        for (slot = 0; slot < 3; slot++)
            plan[2][slot] = 8'($urandom());

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i])
            send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].lst, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].want);

        for (phase = 0; phase < 5; phase++)
        begin
            if (phase > 0)
            begin
                settle_idle();
                for (slot = 0; slot < 3; slot++)
                    write_flag(FLAG_REGS[slot], plan[phase - 1][slot]);
                // the spare index must leave every flags register alone
                if (phase == 1)
                    write_flag(REG_SPARE, 8'hA5);
            end
            idling = (phase < 4);
            if (phase == 2)
            begin
                hold_req = 1'b1;
                send_random_frame(96);
            end
            if (phase == 4)
                send_oversize_frame();
            start = bytes_sent;
            while (bytes_sent - start < RANDOM_BYTES_PER_PHASE)
                send_random_frame(0);
        end
        settle_idle();

        $display("%0d frames in %0d bytes, %0d result beats checked over five flag settings",
                 frames_done, bytes_sent, beats_checked);
        $display("verdicts: ok %0d, short %0d, flags %0d, length %0d, checksum %0d",
                 status_seen[ST_OK], status_seen[ST_TOO_SHORT], status_seen[ST_BAD_FLAGS],
                 status_seen[ST_LEN_ERR], status_seen[ST_CK_ERR]);
        if (mismatches == 0 && pending_beats.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
